// ===== sv/fuel_consumption_computer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Fuel consumption computer assertion macros
// Clocked property checks; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FUEL_CONSUMPTION_COMPUTER_TOP_ASSERT_SVH
`define FUEL_CONSUMPTION_COMPUTER_TOP_ASSERT_SVH
`ifndef SYNTH
// check under reset disable
`define FCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on every edge, reset included
`define FCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCC_ASSERT(lbl, clk, rstn, prop, msg)
`define FCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Widths, register indexes and scale constants of the fuel consumption computer.
// ----------------------------------------------------------------------------
`default_nettype none
package fcc_pkg;

  // divider dividend width: largest product is a 32-bit value times 100000
  localparam int DIV_W  = 49;
  localparam int CNT_W  = 6;

  typedef logic [DIV_W-1:0] dvd_t;
  typedef logic [31:0]      word_t;

  // register indexes
  localparam logic [2:0] REG_SENSOR  = 3'd0;
  localparam logic [2:0] REG_PPL     = 3'd1;
  localparam logic [2:0] REG_CAP     = 3'd2;
  localparam logic [2:0] REG_USR     = 3'd3;
  localparam logic [2:0] REG_MIN_INT = 3'd4;

  localparam logic [15:0] MIN_INT_RST = 16'd1000;

  // scale factors
  localparam int ML_PER_LITRE = 1000;
  localparam int ML_PER_DL    = 100;
  localparam int HUNDRED_KM   = 100000;
  localparam int MS_PER_MIN   = 60000;
  localparam int RANGE_SCALE  = 100;
  localparam int M_PER_DKM    = 10;

endpackage
`default_nettype wire

// ===== sv/fuel_consumption_computer_top.sv =====
// ----------------------------------------------------------------------------
// Fuel consumption computer
// Fuel used/left, average consumption, range and actual consumption per update.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  in_       in    in_tvalid/in_tready  in_tdata  (112 bits, update beat)
//  out_      out   out_tvalid/out_tready out_tdata (184 bits, result beat)
//  cfg_      in    cfg_valid/cfg_ready  cfg_addr, cfg_data (register write)
//
//  Up to five divisions run in turn through one radix-2 restoring divider,
//  each a setup step and 49 quotient bits; fewer run without a sensor, on
//  the first sample or before the interval is reached.
//  Input is taken only while the sequencer is idle; a finished result sits in
//  the output register while the next beat is accepted and computed.
//  A stalled output only holds the sequencer in its final step.
//  rst_n is synchronous; control, configuration and kept state reset at once, there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module fuel_consumption_computer_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pulse_total[31:0], trip_distance_dkm[60:32], odometer_dkm[89:61],
  // clock_ms[105:90], zero pad
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fuel_used_ml[31:0], fuel_left_ml[54:32], avg_ml_per_100km[86:55],
  // range_km[118:87], act_ml_per_100km[150:119], act_ml_per_min[182:151], pad
  output logic [183:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_USED  = 3'd1;
  localparam logic [2:0] S_AVG   = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_FUEL  = 3'd4;
  localparam logic [2:0] S_ACT   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam int DW = fcc_pkg::DIV_W;
  localparam logic [fcc_pkg::CNT_W-1:0] CNT_LAST = fcc_pkg::CNT_W'(DW - 1);

  // configuration
  logic        sensor_r;
  logic [15:0] ppl_r, cap_r, min_int_r;
  logic [7:0]  usr_r;

  // latched beat
  logic [31:0] pulse_r;
  logic [28:0] trip_dkm_r, odo_dkm_r;
  logic [15:0] now_r;

  // kept state
  logic [15:0] prev_time_r;
  logic [31:0] prev_pulses_r, prev_odo_r, moving_r, standing_r;

  // per beat results
  logic [31:0] used_r, avg_r, range_r, fuel_r;
  logic        sel_stand_r;

  logic [2:0]  state_r, step_r;

  // divider
  logic [DW-1:0]              quo_r, quo_nxt;
  logic [31:0]                rem_r, rem_nxt, dvs_r;
  logic [fcc_pkg::CNT_W-1:0]  cnt_r;
  logic [32:0]                rem_sh, rem_sub;
  logic [31:0]                q_sat;

  logic [31:0] out_used_r, out_avg_r, out_range_r, out_mov_r, out_std_r;
  logic [22:0] out_left_r;
  logic        out_valid_r;

  // derived values
  logic [32:0] trip_p, odo_p;
  logic [31:0] trip_m, odo_m, dp, dd;
  logic [15:0] dt;
  logic [22:0] cap_ml, left;
  logic [14:0] usr_ml;

  assign trip_p = 33'(trip_dkm_r) * 33'(fcc_pkg::M_PER_DKM);
  assign odo_p  = 33'(odo_dkm_r) * 33'(fcc_pkg::M_PER_DKM);
  assign trip_m = trip_p[32] ? '1 : trip_p[31:0];
  assign odo_m  = odo_p[32] ? '1 : odo_p[31:0];
  assign dp     = pulse_r - prev_pulses_r;
  assign dd     = odo_m - prev_odo_r;
  assign dt     = now_r - prev_time_r;
  assign cap_ml = 23'(cap_r) * 23'(fcc_pkg::ML_PER_DL);
  assign usr_ml = 15'(usr_r) * 15'(fcc_pkg::ML_PER_DL);
  assign left   = (32'(cap_ml) > used_r) ? cap_ml - used_r[22:0] : '0;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign rem_nxt = rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
  assign quo_nxt = {quo_r[DW-2:0], ~rem_sub[32]};
  assign q_sat   = (quo_nxt[DW-1:32] != '0) ? '1 : quo_nxt[31:0];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_std_r, out_mov_r, out_range_r, out_avg_r,
                       out_left_r, out_used_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r  <= 1'b0;
      ppl_r     <= '0;
      cap_r     <= '0;
      usr_r     <= '0;
      min_int_r <= fcc_pkg::MIN_INT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        fcc_pkg::REG_SENSOR:  sensor_r  <= cfg_data[0];
        fcc_pkg::REG_PPL:     ppl_r     <= cfg_data;
        fcc_pkg::REG_CAP:     cap_r     <= cfg_data;
        fcc_pkg::REG_USR:     usr_r     <= cfg_data[7:0];
        fcc_pkg::REG_MIN_INT: min_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: each setup step loads the divider (the actual step may skip it), the divide step stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_r        <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      prev_time_r   <= '0;
      prev_pulses_r <= '0;
      prev_odo_r    <= '0;
      moving_r      <= '0;
      standing_r    <= '0;
    end else begin
      // the done step reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pulse_r    <= in_tdata[31:0];
            trip_dkm_r <= in_tdata[60:32];
            odo_dkm_r  <= in_tdata[89:61];
            now_r      <= in_tdata[105:90];
            state_r    <= S_USED;
          end
        end
        S_USED: begin
          rem_r  <= '0;
          cnt_r  <= '0;
          step_r <= S_USED;
          state_r <= S_DIV;
          if (sensor_r && ppl_r != '0) begin
            quo_r <= fcc_pkg::dvd_t'(pulse_r) * fcc_pkg::dvd_t'(fcc_pkg::ML_PER_LITRE);
            dvs_r <= 32'(ppl_r);
          end else if (!sensor_r && trip_m != '0) begin
            quo_r <= fcc_pkg::dvd_t'(usr_ml) * fcc_pkg::dvd_t'(trip_m);
            dvs_r <= 32'(fcc_pkg::HUNDRED_KM);
          end else begin
            quo_r <= '0;
            dvs_r <= 32'd1;
          end
        end
        S_AVG: begin
          rem_r  <= '0;
          cnt_r  <= '0;
          step_r <= S_AVG;
          state_r <= S_DIV;
          if (sensor_r && trip_m != '0 && used_r != '0) begin
            quo_r <= fcc_pkg::dvd_t'(used_r) * fcc_pkg::dvd_t'(fcc_pkg::HUNDRED_KM);
            dvs_r <= trip_m;
          end else begin
            quo_r <= fcc_pkg::dvd_t'(usr_ml);
            dvs_r <= 32'd1;
          end
        end
        S_RANGE: begin
          rem_r  <= '0;
          cnt_r  <= '0;
          step_r <= S_RANGE;
          state_r <= S_DIV;
          if (avg_r != '0 && left != '0) begin
            quo_r <= fcc_pkg::dvd_t'(left) * fcc_pkg::dvd_t'(fcc_pkg::RANGE_SCALE);
            dvs_r <= avg_r;
          end else begin
            quo_r <= '0;
            dvs_r <= 32'd1;
          end
        end
        S_FUEL: begin
          rem_r  <= '0;
          cnt_r  <= '0;
          step_r <= S_FUEL;
          state_r <= S_DIV;
          if (ppl_r != '0) begin
            quo_r <= fcc_pkg::dvd_t'(dp) * fcc_pkg::dvd_t'(fcc_pkg::ML_PER_LITRE);
            dvs_r <= 32'(ppl_r);
          end else begin
            quo_r <= '0;
            dvs_r <= 32'd1;
          end
        end
        S_ACT: begin
          // interval reached: take the new sample in any case
          prev_time_r   <= now_r;
          prev_pulses_r <= pulse_r;
          prev_odo_r    <= odo_m;
          rem_r <= '0;
          cnt_r <= '0;
          step_r <= S_ACT;
          if (fuel_r == '0) begin
            moving_r   <= '0;
            standing_r <= '0;
            state_r    <= S_DONE;
          end else if (dd == '0 && dt == '0) begin
            moving_r   <= '0;
            standing_r <= '1;
            state_r    <= S_DONE;
          end else if (dd == '0) begin
            quo_r       <= fcc_pkg::dvd_t'(fuel_r) * fcc_pkg::dvd_t'(fcc_pkg::MS_PER_MIN);
            dvs_r       <= 32'(dt);
            sel_stand_r <= 1'b1;
            state_r     <= S_DIV;
          end else begin
            quo_r       <= fcc_pkg::dvd_t'(fuel_r) * fcc_pkg::dvd_t'(fcc_pkg::HUNDRED_KM);
            dvs_r       <= dd;
            sel_stand_r <= 1'b0;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            unique case (step_r)
              S_USED: begin
                used_r  <= q_sat;
                state_r <= S_AVG;
              end
              S_AVG: begin
                avg_r   <= q_sat;
                state_r <= S_RANGE;
              end
              S_RANGE: begin
                range_r <= q_sat;
                if (!sensor_r) begin
                  moving_r <= 32'(usr_ml);
                  state_r  <= S_DONE;
                end else if (prev_odo_r == '0) begin
                  // first sample: store it, rates start at zero
                  prev_time_r   <= now_r;
                  prev_pulses_r <= pulse_r;
                  prev_odo_r    <= odo_m;
                  moving_r      <= '0;
                  standing_r    <= '0;
                  state_r       <= S_DONE;
                end else begin
                  state_r <= S_FUEL;
                end
              end
              S_FUEL: begin
                fuel_r  <= q_sat;
                state_r <= (dt >= min_int_r) ? S_ACT : S_DONE;
              end
              default: begin
                if (sel_stand_r) begin
                  standing_r <= q_sat;
                  moving_r   <= '0;
                end else begin
                  moving_r   <= q_sat;
                  standing_r <= '0;
                end
                state_r <= S_DONE;
              end
            endcase
          end
        end
        default: begin
          // load the output register once it is free
          if (!out_valid_r || out_tready) begin
            out_used_r  <= used_r;
            out_left_r  <= left;
            out_avg_r   <= avg_r;
            out_range_r <= range_r;
            out_mov_r   <= moving_r;
            out_std_r   <= standing_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

`include "fuel_consumption_computer_top_assert.svh"

  `FCC_ASSERT(a_no_take_busy, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "beat accepted while busy")
  `FCC_ASSERT(a_div_count, clk, rst_n, (state_r == S_DIV) |-> (cnt_r <= CNT_LAST), "divider count overrun")
  `FCC_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result without done step")
  `FCC_ASSERT(a_done_to_idle, clk, rst_n, (state_r == S_DONE && (!out_valid_r || out_tready)) |=> (state_r == S_IDLE && out_valid_r), "done step did not publish")

endmodule
`default_nettype wire
